@@ rtl/core/atst_pkg.sv @@
// Package for the active task slot table.
// Holds the table dimensions, the item layouts and the mode and status codes.
// Depends on nothing.
package atst_pkg;

	localparam int SLOTS       = 16;
	localparam int ID_WIDTH    = 8;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CFG_W       = 5;
	localparam int OUT_IDX_W   = 4;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int IN_BITS     = MODE_W + ID_WIDTH;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = STATUS_W + 1 + 1 + OUT_IDX_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam logic [CFG_W-1:0] NUM_SLOTS_RESET = CFG_W'(16);

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_NO_MATCH = 2'd2
	} status_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} enc_result_t;

endpackage

@@ rtl/core/atst_prio_enc.sv @@
// Lowest-index priority encoder over the slot vector.
// Uses atst_pkg for the slot count and the result struct.
module atst_prio_enc (
	input  logic [atst_pkg::SLOTS-1:0] req,
	output atst_pkg::enc_result_t      result
);
	import atst_pkg::*;

	always_comb begin
		result.found = 1'b0;
		result.index = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (req[i]) begin
				result.found = 1'b1;
				result.index = IDX_W'(i);
			end
		end
	end

endmodule

@@ rtl/core/active_task_slot_table.sv @@
// Top level of the active task slot table: input register, slot table and result register.
// Uses atst_pkg and two instances of atst_prio_enc.
//
// The block accepts one item per cycle while the output is not stalled and presents
// one result item for each. An item is taken into an input register; the next cycle all
// slots in use are compared with its task id in parallel, priority encoders pick the lowest
// free and the lowest matching slot, and the table and the result register are updated at
// the same edge, so the following item already sees the change. Reset empties every slot
// at once. The slot count register may be written only while the block is idle.
module active_task_slot_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             num_slots_we,
	input  logic [atst_pkg::CFG_W-1:0]       num_slots_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0 up: mode, task_id.
	input  logic [atst_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0 up: status, is_active, all_empty, slot_index.
	output logic [atst_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import atst_pkg::*;

	logic [CFG_W-1:0]    num_slots_q;
	logic                valid_s1;
	mode_t               mode_s1;
	logic [ID_WIDTH-1:0] task_id_s1;
	logic                advance;

	logic [ID_WIDTH-1:0] slot_task_q [SLOTS];
	logic [SLOTS-1:0]    slot_valid_q;
	logic [SLOTS-1:0]    slot_valid_d;
	logic [SLOTS-1:0]    in_use;
	logic [SLOTS-1:0]    free_vec;
	logic [SLOTS-1:0]    hit_vec;
	enc_result_t         free_enc;
	enc_result_t         hit_enc;

	logic                out_valid_q;
	status_t             status_q;
	logic                is_active_q;
	logic                all_empty_q;
	logic [OUT_IDX_W-1:0] slot_index_q;

	status_t             status_d;
	logic                is_active_d;
	logic [IDX_W-1:0]    index_d;
	logic                write_slot;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_slots_q <= NUM_SLOTS_RESET;
		end else if (num_slots_we) begin
			num_slots_q <= num_slots_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1    <= mode_t'(s_tdata[MODE_W-1:0]);
			task_id_s1 <= s_tdata[IN_BITS-1:MODE_W];
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			in_use[i]   = (8'(num_slots_q) > 8'(i));
			free_vec[i] = in_use[i] && !slot_valid_q[i];
			hit_vec[i]  = in_use[i] && slot_valid_q[i] && (slot_task_q[i] == task_id_s1);
		end
	end

	atst_prio_enc u_free_enc (
		.req    (free_vec),
		.result (free_enc)
	);

	atst_prio_enc u_hit_enc (
		.req    (hit_vec),
		.result (hit_enc)
	);

	always_comb begin
		status_d     = STATUS_OK;
		is_active_d  = 1'b0;
		index_d      = '0;
		write_slot   = 1'b0;
		slot_valid_d = slot_valid_q;
		case (mode_s1)
			MODE_ADD: begin
				if (free_enc.found) begin
					write_slot                   = 1'b1;
					index_d                      = free_enc.index;
					slot_valid_d[free_enc.index] = 1'b1;
				end else begin
					status_d = STATUS_FULL;
				end
			end
			MODE_REMOVE: begin
				if (hit_enc.found) begin
					index_d                     = hit_enc.index;
					slot_valid_d[hit_enc.index] = 1'b0;
				end else begin
					status_d = STATUS_NO_MATCH;
				end
			end
			MODE_QUERY: begin
				is_active_d = hit_enc.found;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (advance) begin
			slot_valid_q <= slot_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && write_slot) begin
			slot_task_q[free_enc.index] <= task_id_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q     <= status_d;
			is_active_q  <= is_active_d;
			all_empty_q  <= ~|(slot_valid_d & in_use);
			slot_index_q <= OUT_IDX_W'(index_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({slot_index_q, all_empty_q, is_active_q, status_q});

endmodule

@@ tb/tb_active_task_slot_table.sv @@
// Self-checking testbench for the active task slot table.
// Predicts every result item from its own copy of the slot table and compares it field by field.
// Depends on atst_pkg and active_task_slot_table.
module tb_active_task_slot_table;
	timeunit 1ns;
	timeprecision 1ps;

	import atst_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [ID_WIDTH-1:0] task_id;
		logic [MODE_W-1:0]   mode;
	} table_op_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] slot_index;
		logic                 all_empty;
		logic                 is_active;
		status_t              status;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic num_slots_we = 1'b0;
	logic [CFG_W-1:0] num_slots_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	table_op_t pending_ops[$];
	table_result_t expected_results[$];

	logic [ID_WIDTH-1:0] slot_task_id[SLOTS];
	bit slot_held[SLOTS];
	int slot_limit = 16;

	bit quiet = 1'b0;
	int hold_off_requests = 0;
	int hold_off_taken = 0;
	int hold_off_left = 0;
	int errors = 0;
	int cycles = 0;

	active_task_slot_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.num_slots_we    (num_slots_we),
		.num_slots_wdata (num_slots_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int find_task(logic [ID_WIDTH-1:0] id, int used);
		for (int k = 0; k < used; k++) begin
			if (slot_held[k] && slot_task_id[k] == id) begin
				return k;
			end
		end
		return -1;
	endfunction

	function automatic table_result_t apply_op(table_op_t op);
		int used;
		int hit;
		table_result_t r;
		used = (slot_limit > SLOTS) ? SLOTS : slot_limit;
		r = '0;
		r.status = STATUS_OK;
		r.all_empty = 1'b1;
		case (op.mode)
			MODE_ADD: begin
				r.status = STATUS_FULL;
				for (int k = 0; k < used; k++) begin
					if (!slot_held[k]) begin
						slot_held[k] = 1'b1;
						slot_task_id[k] = op.task_id;
						r.status = STATUS_OK;
						r.slot_index = OUT_IDX_W'(k);
						break;
					end
				end
			end
			MODE_REMOVE: begin
				hit = find_task(op.task_id, used);
				if (hit >= 0) begin
					slot_held[hit] = 1'b0;
					r.slot_index = OUT_IDX_W'(hit);
				end else begin
					r.status = STATUS_NO_MATCH;
				end
			end
			MODE_QUERY: begin
				r.is_active = (find_task(op.task_id, used) >= 0);
			end
			default: begin
			end
		endcase
		for (int k = 0; k < used; k++) begin
			if (slot_held[k]) begin
				r.all_empty = 1'b0;
			end
		end
		return r;
	endfunction

	// Sender: presents the oldest pending item and predicts its result on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_op(pending_ops.pop_front()));
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_W'(pending_ops[0]);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result item against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		table_result_t got;
		table_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = table_result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result item: %h", m_tdata);
					end
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status || got.is_active != want.is_active ||
							got.all_empty != want.all_empty || got.slot_index != want.slot_index) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected status %0d active %0b empty %0b slot %0d, got status %0d active %0b empty %0b slot %0d",
								want.status, want.is_active, want.all_empty, want.slot_index,
								got.status, got.is_active, got.all_empty, got.slot_index);
						end
					end
				end
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else if (hold_off_requests != hold_off_taken) begin
				hold_off_taken++;
				hold_off_left = HOLD_OFF_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || $urandom_range(0, 99) >= 34;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_op(logic [MODE_W-1:0] mode, logic [ID_WIDTH-1:0] id);
		table_op_t op;
		op.mode = mode;
		op.task_id = id;
		pending_ops.push_back(op);
	endtask

	task automatic drain();
		while (pending_ops.size() > 0 || expected_results.size() > 0 || s_tvalid) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_slot_count(int count);
		drain();
		num_slots_we <= 1'b1;
		num_slots_wdata <= CFG_W'(count);
		slot_limit = count;
		@(posedge clk);
		num_slots_we <= 1'b0;
	endtask

	initial begin
		logic [ID_WIDTH-1:0] pool[6];
		int count;
		int add_w;
		int rem_w;
		int pick;
		logic [MODE_W-1:0] mode;
		logic [ID_WIDTH-1:0] id;

		for (int k = 0; k < SLOTS; k++) begin
			slot_held[k] = 1'b0;
			slot_task_id[k] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, duplicates, a miss, the unused mode, then fill until full.
		write_slot_count(16);
		push_op(MODE_QUERY, 8'h00);
		push_op(MODE_REMOVE, 8'h00);
		push_op(MODE_ADD, 8'h00);
		push_op(MODE_ADD, 8'hFF);
		push_op(MODE_ADD, 8'hFF);
		push_op(MODE_QUERY, 8'hFF);
		push_op(MODE_REMOVE, 8'hFF);
		push_op(MODE_QUERY, 8'hFF);
		push_op(MODE_REMOVE, 8'hAA);
		push_op(MODE_UNUSED, 8'h55);
		for (int k = 0; k < 14; k++) begin
			push_op(MODE_ADD, ID_WIDTH'($urandom));
		end
		push_op(MODE_ADD, 8'h5A);

		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: count = 1;
				1: count = 0;
				2: count = 31;
				3: count = 16;
				4: count = 17;
				default: count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
					: $urandom_range(1, 16);
			endcase
			write_slot_count(count);
			quiet = (phase == 5);
			if (phase == 5) begin
				hold_off_requests++;
			end
			for (int k = 0; k < 6; k++) begin
				pool[k] = ID_WIDTH'($urandom);
			end
			add_w = $urandom_range(25, 50);
			rem_w = $urandom_range(25, 45);
			for (int n = 0; n < 118; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < add_w) begin
					mode = MODE_ADD;
				end else if (pick < add_w + rem_w) begin
					mode = MODE_REMOVE;
				end else if (pick < 95) begin
					mode = MODE_QUERY;
				end else begin
					mode = MODE_UNUSED;
				end
				if ($urandom_range(0, 4) == 0) begin
					id = ID_WIDTH'($urandom);
				end else begin
					id = pool[$urandom_range(0, 5)];
				end
				push_op(mode, id);
			end
		end

		drain();
		quiet = 1'b0;
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
